// ===== sv/pcss_pkg.sv =====
// pcss_pkg: shared types, codes and the microcode rom of the punch card sequencer
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package pcss_pkg;

    // item operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_PAUSE_TICKS = 3'd0;
    localparam logic [2:0] CFG_STROKE_STEPS = 3'd1;
    localparam logic [2:0] CFG_TURN_STEPS = 3'd2;
    localparam logic [2:0] CFG_COL_PITCH = 3'd3;
    localparam logic [2:0] CFG_ROW_PITCH = 3'd4;

    // configuration reset values
    localparam logic [9:0] RST_PAUSE_TICKS = 10'd133;
    localparam logic [7:0] RST_STROKE_STEPS = 8'd25;
    localparam logic [9:0] RST_TURN_STEPS = 10'd150;
    localparam logic [7:0] RST_COL_PITCH = 8'd56;
    localparam logic [7:0] RST_ROW_PITCH = 8'd56;

    // ascii digit range
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // motion segments, also the program counter of the sequencer
    typedef enum logic [3:0] {
        SEG_IDLE    = 4'd0,
        SEG_DOWN    = 4'd1,
        SEG_PAUSE1  = 4'd2,
        SEG_TURN    = 4'd3,
        SEG_PAUSE2  = 4'd4,
        SEG_UP      = 4'd5,
        SEG_PAUSE3  = 4'd6,
        SEG_FEED    = 4'd7,
        SEG_RETURN  = 4'd8,
        SEG_ADVANCE = 4'd9,
        SEG_HOME    = 4'd10
    } t_seg;

    typedef enum logic [1:0] {
        K_IDLE,
        K_PAUSE,
        K_MOVE
    } t_kind;

    typedef enum logic [1:0] {
        M_PUNCH,
        M_FEED,
        M_ADV
    } t_motor;

    typedef enum logic [2:0] {
        L_STROKE,
        L_TURN,
        L_PITCH,
        L_RETURN,
        L_ROW,
        L_HOME
    } t_len;

    typedef enum logic [2:0] {
        J_NEXT,
        J_COLUMN,
        J_LASTCOL,
        J_ROW,
        J_IDLE
    } t_jump;

    // one control word of the program
    typedef struct packed {
        t_kind  kind;
        t_motor motor;
        logic   fwd;
        t_len   len;
        t_jump  jump;
        t_seg   nxt;
    } t_uword;

    // control from sequencer to datapath
    typedef struct packed {
        logic   tick;
        logic   start;
        t_uword uw;
    } t_dp_ctl;

    // status from datapath to sequencer
    typedef struct packed {
        logic pause_done;
        logic step_done;
    } t_dp_stat;

    typedef struct packed {
        logic [9:0] pause_ticks;
        logic [7:0] stroke_steps;
        logic [9:0] turn_steps;
        logic [7:0] column_pitch_steps;
        logic [7:0] row_pitch_steps;
    } t_cfg;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [3:0] punch_phase;
        logic [3:0] feed_phase;
        logic [3:0] advance_phase;
        logic       busy_res;
        logic       char_dropped;
    } t_out;

    // microcode rom, one word per segment
    function automatic t_uword ucode(input t_seg seg);
        t_uword w;
        w = '{kind: K_IDLE, motor: M_PUNCH, fwd: 1'b0, len: L_STROKE,
              jump: J_NEXT, nxt: SEG_IDLE};
        unique case (seg)
            SEG_DOWN:    w = '{K_MOVE,  M_PUNCH, 1'b1, L_STROKE, J_NEXT,    SEG_PAUSE1};
            SEG_PAUSE1:  w = '{K_PAUSE, M_PUNCH, 1'b0, L_STROKE, J_NEXT,    SEG_TURN};
            SEG_TURN:    w = '{K_MOVE,  M_PUNCH, 1'b0, L_TURN,   J_NEXT,    SEG_PAUSE2};
            SEG_PAUSE2:  w = '{K_PAUSE, M_PUNCH, 1'b0, L_STROKE, J_NEXT,    SEG_UP};
            SEG_UP:      w = '{K_MOVE,  M_PUNCH, 1'b0, L_STROKE, J_NEXT,    SEG_PAUSE3};
            SEG_PAUSE3:  w = '{K_PAUSE, M_PUNCH, 1'b0, L_STROKE, J_LASTCOL, SEG_FEED};
            SEG_FEED:    w = '{K_MOVE,  M_FEED,  1'b0, L_PITCH,  J_COLUMN,  SEG_FEED};
            SEG_RETURN:  w = '{K_MOVE,  M_FEED,  1'b1, L_RETURN, J_NEXT,    SEG_ADVANCE};
            SEG_ADVANCE: w = '{K_MOVE,  M_ADV,   1'b1, L_ROW,    J_ROW,     SEG_HOME};
            SEG_HOME:    w = '{K_MOVE,  M_ADV,   1'b0, L_HOME,   J_IDLE,    SEG_IDLE};
            default:     w = '{K_IDLE,  M_PUNCH, 1'b0, L_STROKE, J_NEXT,    SEG_IDLE};
        endcase
        return w;
    endfunction

    // coil pattern for one phase, forward 8,2,4,1 and reverse 1,4,2,8
    function automatic logic [3:0] coil_phase(input logic fwd, input logic [1:0] ph);
        logic [3:0] v;
        v = 4'h0;
        case (ph)
            2'd0: v = fwd ? 4'h8 : 4'h1;
            2'd1: v = fwd ? 4'h2 : 4'h4;
            2'd2: v = fwd ? 4'h4 : 4'h2;
            default: v = fwd ? 4'h1 : 4'h8;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pcss_loader.sv =====
// pcss_loader: digit collection and row pattern store of the punch card sequencer
// depends on pcss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcss_loader #(
    parameter int ROWS = 5,
    localparam int PIDX_W = $clog2(ROWS > 1 ? ROWS : 2)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_char,
    input  wire logic [PIDX_W-1:0] i_rd_row,
    output logic      [7:0]        o_rd_pat,
    output logic                   o_start
);
    import pcss_pkg::*;

    localparam int DC_W = $clog2(ROWS * 4);
    localparam logic [DC_W-1:0] DC_LAST = DC_W'(ROWS * 4 - 1);

    logic [DC_W-1:0] r_dc, n_dc;
    logic [3:0]      r_hold [3];
    logic [7:0]      r_pat  [ROWS];

    logic [3:0]        digit;
    logic [7:0]        x_val, z_val;
    logic [7:0]        row_pat;
    logic              pat_we;
    logic [PIDX_W-1:0] wr_row;

    // repair non-digits to zero
    assign digit = (i_char >= CH_ZERO && i_char <= CH_NINE) ? i_char[3:0] : 4'd0;

    // two-digit numbers and the column pattern
    always_comb begin
        x_val = ({4'd0, r_hold[0]} << 3) + ({4'd0, r_hold[0]} << 1) + {4'd0, r_hold[1]};
        z_val = ({4'd0, r_hold[2]} << 3) + ({4'd0, r_hold[2]} << 1) + {4'd0, digit};
        row_pat = {z_val[0], z_val[1], z_val[2], x_val[0], x_val[1], x_val[2], x_val[3],
                   1'b1};
        pat_we = i_take && (r_dc[1:0] == 2'd3);
        wr_row = PIDX_W'(r_dc >> 2);
    end

    // digit counter
    always_comb begin
        n_dc = r_dc;
        o_start = 1'b0;
        if (i_take) begin
            if (r_dc == DC_LAST) begin
                n_dc = '0;
                o_start = 1'b1;
            end else begin
                n_dc = r_dc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= '0;
        end else begin
            r_dc <= n_dc;
        end
    end

    // digit hold and pattern store
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            case (r_dc[1:0])
                2'd0: r_hold[0] <= digit;
                2'd1: r_hold[1] <= digit;
                2'd2: r_hold[2] <= digit;
                default: ;
            endcase
        end
        if (pat_we) begin
            r_pat[wr_row] <= row_pat;
        end
    end

    // read port, bypassing a write to the same row
    always_comb begin
        o_rd_pat = 8'd0;
        if (pat_we && wr_row == i_rd_row) begin
            o_rd_pat = row_pat;
        end else if ({1'b0, i_rd_row} < (PIDX_W + 1)'(ROWS)) begin
            o_rd_pat = r_pat[i_rd_row];
        end
    end

endmodule

`default_nettype wire

// ===== sv/pcss_datapath.sv =====
// pcss_datapath: step, phase and pause counters and the three coil registers
// depends on pcss_pkg; driven by the control word of pcss_sequencer
`timescale 1ns / 1ps
`default_nettype none

module pcss_datapath #(
    parameter int COLUMNS = 8,
    parameter int ROWS = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcss_pkg::t_cfg    i_cfg,
    input  wire pcss_pkg::t_dp_ctl i_ctl,
    output pcss_pkg::t_dp_stat     o_stat,
    output logic [3:0]             o_punch,
    output logic [3:0]             o_feed,
    output logic [3:0]             o_adv
);
    import pcss_pkg::*;

    localparam int MAXK_A = (COLUMNS - 1 > ROWS) ? COLUMNS - 1 : ROWS;
    localparam int MAXK = (MAXK_A > 5) ? MAXK_A : 5;
    localparam int STEP_W = $clog2(MAXK * 255 + 1);

    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_phase, n_phase;
    logic [9:0]        r_pause, n_pause;
    logic [3:0]        r_punch, n_punch;
    logic [3:0]        r_feed, n_feed;
    logic [3:0]        r_adv, n_adv;

    logic [9:0]        pause1, turn1;
    logic [7:0]        stroke1, colp1, rowp1;
    logic [STEP_W-1:0] total;
    logic [STEP_W:0]   step_inc;
    logic [10:0]       pause_inc;
    logic [3:0]        coil;

    // a zero register acts as one
    always_comb begin
        pause1  = (i_cfg.pause_ticks == '0) ? 10'd1 : i_cfg.pause_ticks;
        turn1   = (i_cfg.turn_steps == '0) ? 10'd1 : i_cfg.turn_steps;
        stroke1 = (i_cfg.stroke_steps == '0) ? 8'd1 : i_cfg.stroke_steps;
        colp1   = (i_cfg.column_pitch_steps == '0) ? 8'd1 : i_cfg.column_pitch_steps;
        rowp1   = (i_cfg.row_pitch_steps == '0) ? 8'd1 : i_cfg.row_pitch_steps;
    end

    // segment length in full steps
    always_comb begin
        case (i_ctl.uw.len)
            L_STROKE: total = STEP_W'(stroke1);
            L_TURN:   total = STEP_W'(turn1);
            L_PITCH:  total = STEP_W'(colp1);
            L_RETURN: total = STEP_W'((COLUMNS - 1) * colp1);
            L_ROW:    total = STEP_W'(rowp1);
            default:  total = STEP_W'(ROWS * rowp1);
        endcase
    end

    // counter and coil updates for one tick
    always_comb begin
        n_step  = r_step;
        n_phase = r_phase;
        n_pause = r_pause;
        n_punch = r_punch;
        n_feed  = r_feed;
        n_adv   = r_adv;
        o_stat  = '0;
        step_inc  = {1'b0, r_step} + 1'b1;
        pause_inc = {1'b0, r_pause} + 1'b1;
        coil = coil_phase(i_ctl.uw.fwd, r_phase);
        if (i_ctl.start) begin
            n_step  = '0;
            n_phase = '0;
            n_pause = '0;
        end else if (i_ctl.tick && i_ctl.uw.kind == K_PAUSE) begin
            if (pause_inc >= {1'b0, pause1}) begin
                o_stat.pause_done = 1'b1;
                n_pause = '0;
                n_step  = '0;
                n_phase = '0;
            end else begin
                n_pause = pause_inc[9:0];
            end
        end else if (i_ctl.tick && i_ctl.uw.kind == K_MOVE) begin
            case (i_ctl.uw.motor)
                M_PUNCH: n_punch = coil;
                M_FEED:  n_feed = coil;
                default: n_adv = coil;
            endcase
            n_phase = r_phase + 1'b1;
            if (r_phase == 2'd3) begin
                if (step_inc >= {1'b0, total}) begin
                    o_stat.step_done = 1'b1;
                    n_step  = '0;
                    n_pause = '0;
                end else begin
                    n_step = step_inc[STEP_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_phase <= '0;
            r_pause <= '0;
            r_punch <= '0;
            r_feed  <= '0;
            r_adv   <= '0;
        end else begin
            r_step  <= n_step;
            r_phase <= n_phase;
            r_pause <= n_pause;
            r_punch <= n_punch;
            r_feed  <= n_feed;
            r_adv   <= n_adv;
        end
    end

    assign o_punch = r_punch;
    assign o_feed  = r_feed;
    assign o_adv   = r_adv;

endmodule

`default_nettype wire

// ===== sv/pcss_sequencer.sv =====
// pcss_sequencer: segment program counter, microcode fetch and jump logic
// depends on pcss_pkg; reads row patterns from pcss_loader
`timescale 1ns / 1ps
`default_nettype none

module pcss_sequencer #(
    parameter int COLUMNS = 8,
    parameter int ROWS = 5,
    localparam int PIDX_W = $clog2(ROWS > 1 ? ROWS : 2)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tick,
    input  wire logic               i_start,
    input  wire pcss_pkg::t_dp_stat i_stat,
    input  wire logic [7:0]         i_rd_pat,
    output logic [PIDX_W-1:0]       o_rd_row,
    output pcss_pkg::t_dp_ctl       o_ctl,
    output logic                    o_busy
);
    import pcss_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_END = ROW_W'(ROWS);

    t_seg             r_seg, n_seg;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    t_uword           uw;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] row_nx;
    logic [COL_W-1:0] col_nx;
    logic [3:0]       col4;
    logic             col_set;
    t_seg             begin_seg;
    logic             done;

    // fetch the control word of the current segment
    always_comb begin
        uw = ucode(r_seg);
        o_busy = (r_seg != SEG_IDLE);
        o_ctl.tick  = i_tick;
        o_ctl.start = i_start;
        o_ctl.uw    = uw;
    end

    // row and column that the next column test looks at
    always_comb begin
        row_inc = r_row + 1'b1;
        done = i_stat.pause_done || i_stat.step_done;
        row_nx = r_row;
        col_nx = r_col;
        if (i_start) begin
            row_nx = '0;
            col_nx = '0;
        end else if (uw.jump == J_COLUMN) begin
            col_nx = r_col + 1'b1;
        end else if (uw.jump == J_ROW) begin
            row_nx = row_inc;
            col_nx = '0;
        end
        o_rd_row = PIDX_W'(row_nx);
        col4 = 4'(col_nx);
        col_set = !col4[3] && i_rd_pat[col4[2:0]];
        if (col_set) begin
            begin_seg = SEG_DOWN;
        end else if (col_nx < LAST_COL) begin
            begin_seg = SEG_FEED;
        end else begin
            begin_seg = SEG_RETURN;
        end
    end

    // next segment, row and column
    always_comb begin
        n_seg = r_seg;
        n_row = r_row;
        n_col = r_col;
        if (i_start) begin
            n_row = '0;
            n_col = '0;
            n_seg = begin_seg;
        end else if (done) begin
            unique case (uw.jump)
                J_NEXT: begin
                    n_seg = uw.nxt;
                end
                J_COLUMN: begin
                    n_col = col_nx;
                    n_seg = begin_seg;
                end
                J_LASTCOL: begin
                    n_seg = (r_col < LAST_COL) ? SEG_FEED : SEG_RETURN;
                end
                J_ROW: begin
                    n_row = row_inc;
                    if (row_inc >= ROW_END) begin
                        n_seg = SEG_HOME;
                    end else begin
                        n_col = '0;
                        n_seg = begin_seg;
                    end
                end
                J_IDLE: begin
                    n_seg = SEG_IDLE;
                    n_row = '0;
                    n_col = '0;
                end
                default: begin
                    n_seg = SEG_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_IDLE;
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_seg <= n_seg;
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

// ===== sv/punch_card_stepper_sequencer.sv =====
// punch_card_stepper_sequencer: top level with handshakes, configuration and result word
// depends on pcss_pkg, pcss_loader, pcss_datapath and pcss_sequencer
//
// Input words carry an operation bit and a character: operation 0 is a received
// character, operation 1 is one timer tick. Every accepted word gives one result
// word with the three coil drives, the busy flag and a dropped-character flag.
// Characters are collected while idle; the ROWS*4-th digit starts the card and
// ticks then walk the motion program, one coil phase per tick in a move segment.
// The result is valid in the cycle after the word is accepted. Throughput: one
// word per cycle unless the receiver stalls; each word does one counter step of
// the sequencer program. The result is held in the state registers themselves,
// so the input is taken again in the same cycle the result is taken. When the
// receiver stalls, the result holds and the input is not ready until it is taken.
// Configuration writes are registered, with no handshake; the user must make them
// while the block is idle, as the block itself does not enforce this.
// Reset (synchronous, active low) restores the register defaults, clears the
// digit count, returns to idle and turns all coils off; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module punch_card_stepper_sequencer #(
    parameter int COLUMNS = 8,
    parameter int ROWS = 5
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pcss_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pcss_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [9:0]     i_cfg_data
);
    import pcss_pkg::*;

    localparam int PIDX_W = $clog2(ROWS > 1 ? ROWS : 2);

    t_cfg r_cfg;
    logic r_out_valid, n_out_valid;
    logic r_dropped, n_dropped;

    logic              in_acc;
    logic              tick;
    logic              take;
    logic              start;
    logic              busy;
    logic [PIDX_W-1:0] rd_row;
    logic [7:0]        rd_pat;
    t_dp_ctl           ctl;
    t_dp_stat          stat;
    logic [3:0]        punch, feed, adv;

    // input handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc = i_in_valid && o_in_ready;
    assign tick = in_acc && (i_in_data.operation == OP_TICK);
    assign take = in_acc && (i_in_data.operation == OP_CHAR) && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pause_ticks        <= RST_PAUSE_TICKS;
            r_cfg.stroke_steps       <= RST_STROKE_STEPS;
            r_cfg.turn_steps         <= RST_TURN_STEPS;
            r_cfg.column_pitch_steps <= RST_COL_PITCH;
            r_cfg.row_pitch_steps    <= RST_ROW_PITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAUSE_TICKS:  r_cfg.pause_ticks <= i_cfg_data;
                CFG_STROKE_STEPS: r_cfg.stroke_steps <= i_cfg_data[7:0];
                CFG_TURN_STEPS:   r_cfg.turn_steps <= i_cfg_data;
                CFG_COL_PITCH:    r_cfg.column_pitch_steps <= i_cfg_data[7:0];
                CFG_ROW_PITCH:    r_cfg.row_pitch_steps <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    pcss_loader #(.ROWS(ROWS)) u_loader (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_char   (i_in_data.char_code),
        .i_rd_row (rd_row),
        .o_rd_pat (rd_pat),
        .o_start  (start)
    );

    pcss_sequencer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_start  (start),
        .i_stat   (stat),
        .i_rd_pat (rd_pat),
        .o_rd_row (rd_row),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    pcss_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_punch (punch),
        .o_feed  (feed),
        .o_adv   (adv)
    );

    // result word valid and dropped flag
    always_comb begin
        n_out_valid = r_out_valid;
        n_dropped = r_dropped;
        if (in_acc) begin
            n_out_valid = 1'b1;
            n_dropped = (i_in_data.operation == OP_CHAR) && busy;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_dropped   <= n_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data.punch_phase   = punch;
    assign o_out_data.feed_phase    = feed;
    assign o_out_data.advance_phase = adv;
    assign o_out_data.busy_res      = busy;
    assign o_out_data.char_dropped  = r_dropped;

    // a character taken while busy is flagged in its result
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_CHAR && busy) |=> o_out_data.char_dropped)
        else $error("busy character not flagged as dropped");

    // a tick while idle moves no coil
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick && !busy) |=> ($stable(punch) && $stable(feed) && $stable(adv)))
        else $error("coil changed on an idle tick");

    // the last digit of a card starts the program
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy)
        else $error("card start did not leave idle");

    // coils drive at most one phase each
    a_coil_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($onehot0(punch) && $onehot0(feed) && $onehot0(adv)))
        else $error("coil drive is not one-hot");

endmodule

`default_nettype wire
